// ===== sv/brf_pkg.sv =====
// Package for burst_ring_fifo_unit: field widths, request codes, defaults
// and the packed request and response types. No dependencies.
`default_nettype none

package brf_pkg;

   localparam int OP_W    = 2;
   localparam int DATA_W  = 8;
   localparam int COUNT_W = 7;
   localparam int SIZE_W  = 9;
   localparam int CFG_W   = 4;

   localparam int DEPTH_DEFAULT        = 256;
   localparam int ELEMENT_BITS_DEFAULT = 8;
   localparam int MAX_BURST_DEFAULT    = 64;
   localparam int CAP_LOG2_LIMIT       = 8;
   localparam logic [CFG_W-1:0] CAP_LOG2_RESET = 4'd8;

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]    req_type;
      logic [DATA_W-1:0]  push_data;
      logic               push_last;
      logic [COUNT_W-1:0] request_count;
   } brf_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] element;
      logic              element_valid;
      logic              accepted;
      logic [SIZE_W-1:0] run_count;
      logic [SIZE_W-1:0] free_space;
      logic              last;
   } brf_rsp_type;

endpackage

`default_nettype wire

// ===== sv/burst_ring_fifo_unit.sv =====
// Top level of the burst ring FIFO: pointer control, burst sequencer and
// response register around one brf_ram. Depends on brf_pkg and brf_ram.
`default_nettype none

// Ring FIFO with a configurable power-of-two capacity (2 up to the largest
// power of two that fits DEPTH, at most 256). A push, and a pop or peek that
// finds nothing, get a single response; an unknown request gets none. A pop
// or peek that delivers n elements starts a burst, issues the registered RAM
// read, then returns one element per cycle while rsp_stall does not hold the
// response register, since the sequencer keeps a single read in flight on the
// RAM's read port. New requests are taken only while no burst is running,
// the response register is free to move and no csr write is offered. Writing
// csr_data sets log2 of the capacity and empties the FIFO.
module burst_ring_fifo_unit #(
   parameter int DEPTH        = brf_pkg::DEPTH_DEFAULT,
   parameter int ELEMENT_BITS = brf_pkg::ELEMENT_BITS_DEFAULT,
   parameter int MAX_BURST    = brf_pkg::MAX_BURST_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire brf_pkg::brf_req_type      req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output brf_pkg::brf_rsp_type           rsp_payload,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [brf_pkg::CFG_W-1:0] csr_data
);

   localparam int FLOOR_LOG2 = $clog2(DEPTH + 1) - 1;
   localparam int AW = (FLOOR_LOG2 < brf_pkg::CAP_LOG2_LIMIT) ?
                       FLOOR_LOG2 : brf_pkg::CAP_LOG2_LIMIT;
   localparam int PW = AW + 1;
   localparam int MEM_DEPTH = 1 << AW;
   localparam int SW = (ELEMENT_BITS < brf_pkg::DATA_W) ? ELEMENT_BITS : brf_pkg::DATA_W;
   localparam int CW = brf_pkg::COUNT_W;

   typedef enum logic {
      ST_IDLE,
      ST_BURST
   } state_type;

   state_type               state_ff, state_in;
   logic [PW-1:0]           cap_ff, cap_in;
   logic [PW-1:0]           wp_ff, wp_in;
   logic [PW-1:0]           rp_ff, rp_in;
   logic [brf_pkg::SIZE_W-1:0] run_ff, run_in;
   logic                    pop_ff, pop_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [CW-1:0]           iss_ff, iss_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [PW-1:0]           ptr_ff, ptr_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   brf_pkg::brf_rsp_type    rsp_ff, rsp_in;

   logic                    out_free, req_acc, csr_acc;
   logic [AW-1:0]           amask;
   logic [PW-1:0]           pmask, used, used_after, rp_step;
   logic                    full, load, issue;
   logic [CW-1:0]           cmax, nreq, cnt_next;
   logic [brf_pkg::SIZE_W-1:0] run_next;
   logic [brf_pkg::CFG_W-1:0]  eff_log2;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [SW-1:0]           wr_data, rd_data;

   brf_ram #(
      .WIDTH (SW),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && out_free && !csr_valid);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_acc   = csr_valid && csr_ready;

   assign amask = AW'(cap_ff - PW'(1));
   assign pmask = {amask, 1'b1};
   assign used  = (wp_ff - rp_ff) & pmask;
   assign full  = (used == cap_ff);

   assign wr_en   = req_acc && req_payload.req_type == brf_pkg::OP_PUSH && !full;
   assign wr_addr = wp_ff[AW-1:0] & amask;
   assign wr_data = SW'(req_payload.push_data);
   assign rd_addr = ptr_ff[AW-1:0] & amask;

   assign load  = (state_ff == ST_BURST) && pend_ff && out_free;
   assign issue = (state_ff == ST_BURST) && (iss_ff != n_ff) && (!pend_ff || load);

   assign cmax = (req_payload.request_count > CW'(MAX_BURST)) ?
                 CW'(MAX_BURST) : req_payload.request_count;
   assign nreq = (16'(cmax) > 16'(used)) ? CW'(used) : cmax;
   assign cnt_next = cnt_ff + CW'(1);
   assign run_next = run_ff + brf_pkg::SIZE_W'(1);
   assign rp_step  = (rp_ff + PW'(1)) & pmask;
   assign eff_log2 = (csr_data < 4'd1) ? 4'd1 :
                     (csr_data > brf_pkg::CFG_W'(AW)) ? brf_pkg::CFG_W'(AW) : csr_data;

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      run_in       = run_ff;
      pop_in       = pop_ff;
      n_in         = n_ff;
      iss_in       = iss_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      pend_in      = issue || (pend_ff && !load);
      rsp_valid_in = rsp_valid_ff && !out_free;
      rsp_in       = rsp_ff;
      used_after   = used;

      if (csr_acc) begin
         cap_in = PW'(1) << eff_log2;
         wp_in  = '0;
         rp_in  = '0;
      end

      if (req_acc) begin
         case (req_payload.req_type)
            brf_pkg::OP_PUSH: begin
               rsp_valid_in          = 1'b1;
               rsp_in                = '0;
               rsp_in.accepted       = !full;
               rsp_in.last           = req_payload.push_last;
               rsp_in.run_count      = full ? run_ff : run_next;
               rsp_in.free_space     = brf_pkg::SIZE_W'(cap_ff - used
                                                       - PW'(!full));
               if (!full) begin
                  wp_in  = (wp_ff + PW'(1)) & pmask;
                  run_in = run_next;
               end
               if (req_payload.push_last) begin
                  run_in = '0;
               end
            end
            brf_pkg::OP_POP, brf_pkg::OP_PEEK: begin
               if (nreq == '0) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in            = '0;
                  rsp_in.free_space = brf_pkg::SIZE_W'(cap_ff - used);
                  rsp_in.last       = 1'b1;
               end else begin
                  state_in = ST_BURST;
                  pop_in   = (req_payload.req_type == brf_pkg::OP_POP);
                  n_in     = nreq;
                  iss_in   = '0;
                  cnt_in   = '0;
                  ptr_in   = rp_ff;
               end
            end
            default: begin
            end
         endcase
      end

      if (issue) begin
         ptr_in = (ptr_ff + PW'(1)) & pmask;
         iss_in = iss_ff + CW'(1);
      end

      if (load) begin
         cnt_in = cnt_next;
         if (pop_ff) begin
            rp_in      = rp_step;
            used_after = (wp_ff - rp_step) & pmask;
         end
         rsp_valid_in         = 1'b1;
         rsp_in               = '0;
         rsp_in.element       = brf_pkg::DATA_W'(rd_data);
         rsp_in.element_valid = 1'b1;
         rsp_in.run_count     = brf_pkg::SIZE_W'(cnt_next);
         rsp_in.free_space    = brf_pkg::SIZE_W'(cap_ff - used_after);
         rsp_in.last          = (cnt_next == n_ff);
         if (cnt_next == n_ff) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= PW'(1) << ((brf_pkg::CAP_LOG2_RESET > brf_pkg::CFG_W'(AW)) ?
                                    brf_pkg::CFG_W'(AW) : brf_pkg::CAP_LOG2_RESET);
         wp_ff        <= '0;
         rp_ff        <= '0;
         run_ff       <= '0;
         pop_ff       <= 1'b0;
         n_ff         <= '0;
         iss_ff       <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         run_ff       <= run_in;
         pop_ff       <= pop_in;
         n_ff         <= n_in;
         iss_ff       <= iss_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_used_le_cap: assert property (@(posedge clock) disable iff (reset)
      used <= cap_ff)
      else $error("fill level above capacity");

   a_pend_in_burst: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_BURST)
      else $error("read in flight outside a burst");

   a_emit_le_issue: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BURST |-> (cnt_ff <= iss_ff && iss_ff <= n_ff))
      else $error("burst counters out of order");

   a_no_write_in_burst: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BURST |-> !wr_en)
      else $error("RAM write during a burst");

endmodule

`default_nettype wire

// ===== sv/brf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
